/* hw/rtl/gvs_pkg.sv */
`timescale 1ns / 1ps
package gvs_pkg;

  localparam int SLOT_COUNT_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] FREE_MARK  = 16'hFFFF;
  localparam logic [7:0]  SHORT_MASK = 8'h3F;

  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_SHORT = 4'd1;
  localparam logic [3:0] LEN_BYTE  = 4'd2;
  localparam logic [3:0] LEN_WORD  = 4'd3;

  typedef enum logic [1:0] {
    OUT_UPDATED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_IGNORED  = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [15:0] group_address;
    logic [3:0]  length_field;
    logic [7:0]  short_payload;
    logic [7:0]  payload_high;
    logic [7:0]  payload_low;
  } req_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  slot_index;
    logic [15:0] stored_value;
  } result_item_t;

  typedef struct packed {
    logic        lookup;
    logic [15:0] group_address;
    logic [15:0] value;
  } work_item_t;

  typedef struct packed {
    logic [15:0] group_address;
    logic [15:0] value;
  } slot_entry_t;

endpackage

/* hw/rtl/group_value_store_core.sv */
`timescale 1ns / 1ps
// Sequence: an ignored length goes from the queue straight to the emit state; a lookup first
//   runs the one-read-per-cycle slot scan, which stops at a match, over the occupied slots
//   (F of them, at most SLOT_COUNT; none on an empty table).
// Overlap: the back end holds one request at a time, from its scan to its emitted result.
//   A two-entry queue lets requests be taken while the scan or the output waits.
// Reset: clears the fill count, queue and handshakes; the slot memory itself
//   is not swept, slots at or beyond the fill count are treated as free.
module group_value_store_core #(
  parameter int SLOT_COUNT  = gvs_pkg::SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = gvs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  gvs_pkg::req_item_t    req,
  output logic                  result_valid,
  input  logic                  result_ready,
  output gvs_pkg::result_item_t result
);

  logic                push_valid;
  logic                push_ready;
  gvs_pkg::work_item_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  gvs_pkg::work_item_t pop_data;

  gvs_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gvs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gvs_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* hw/rtl/gvs_ram.sv */
`timescale 1ns / 1ps
module gvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/gvs_fifo.sv */
`timescale 1ns / 1ps
module gvs_fifo #(
  parameter int DEPTH = gvs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  gvs_pkg::work_item_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output gvs_pkg::work_item_t pop_data
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  gvs_pkg::work_item_t store [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

/* hw/rtl/gvs_front.sv */
`timescale 1ns / 1ps
module gvs_front (
  input  logic                req_valid,
  output logic                req_ready,
  input  gvs_pkg::req_item_t  req,
  output logic                push_valid,
  input  logic                push_ready,
  output gvs_pkg::work_item_t push_data
);

  logic [15:0] value;

  always_comb begin
    case (req.length_field)
      gvs_pkg::LEN_SHORT: value = {8'h00, req.short_payload & gvs_pkg::SHORT_MASK};
      gvs_pkg::LEN_BYTE:  value = {8'h00, req.payload_high};
      gvs_pkg::LEN_WORD:  value = {req.payload_high, req.payload_low};
      default:            value = 16'h0000;
    endcase
  end

  always_comb begin
    push_data.lookup        = req.length_field inside {[gvs_pkg::LEN_NONE:gvs_pkg::LEN_WORD]};
    push_data.group_address = req.group_address;
    push_data.value         = value;
  end

  assign push_valid = req_valid;
  assign req_ready  = push_ready;

endmodule

/* hw/rtl/gvs_back.sv */
`timescale 1ns / 1ps
module gvs_back #(
  parameter int SLOT_COUNT = gvs_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  gvs_pkg::work_item_t   pop_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output gvs_pkg::result_item_t result
);

  localparam int IDXW = $clog2(SLOT_COUNT);
  localparam int CNTW = $clog2(SLOT_COUNT + 1);

  gvs_pkg::back_state_t  state;
  gvs_pkg::back_state_t  state_next;
  gvs_pkg::work_item_t   work;
  gvs_pkg::result_item_t res;
  gvs_pkg::result_item_t res_next;
  gvs_pkg::slot_entry_t  rd_entry;
  gvs_pkg::slot_entry_t  wr_entry;

  // occupied slots always form a prefix [0, fill)
  logic [CNTW-1:0] fill;
  logic [CNTW-1:0] rd_idx;
  logic [IDXW-1:0] chk_idx;
  logic            chk_valid;

  logic            match;
  logic            scan_done;
  logic            has_room;
  logic            ram_re;
  logic            ram_we;
  logic [IDXW-1:0] ram_waddr;
  logic            res_load;
  logic            fill_inc;
  logic            emit_free;
  logic [IDXW+7:0] slot_wide_chk;
  logic [IDXW+7:0] slot_wide_ins;

  assign match     = (state == gvs_pkg::ST_SCAN) && chk_valid &&
                     (rd_entry.group_address == work.group_address);
  assign scan_done = (state == gvs_pkg::ST_SCAN) && !chk_valid && (rd_idx >= fill);
  assign has_room  = (fill < CNTW'(SLOT_COUNT));
  assign emit_free = !result_valid || result_ready;

  assign slot_wide_chk = {8'h00, chk_idx};
  assign slot_wide_ins = {8'h00, fill[IDXW-1:0]};

  assign wr_entry.group_address = work.group_address;
  assign wr_entry.value         = work.value;

  gvs_ram #(
    .WIDTH ($bits(gvs_pkg::slot_entry_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (rd_idx[IDXW-1:0]),
    .rdata (rd_entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      gvs_pkg::ST_IDLE: begin
        if (pop_valid) begin
          state_next = pop_data.lookup ? gvs_pkg::ST_SCAN : gvs_pkg::ST_EMIT;
        end
      end
      gvs_pkg::ST_SCAN: begin
        if (match || scan_done) begin
          state_next = gvs_pkg::ST_EMIT;
        end
      end
      gvs_pkg::ST_EMIT: begin
        if (emit_free) begin
          state_next = gvs_pkg::ST_IDLE;
        end
      end
      default: state_next = gvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fill[IDXW-1:0];
    res_load  = 1'b0;
    fill_inc  = 1'b0;
    res_next  = res;
    case (state)
      gvs_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid && !pop_data.lookup) begin
          res_load              = 1'b1;
          res_next.outcome      = gvs_pkg::OUT_IGNORED;
          res_next.slot_index   = 8'h00;
          res_next.stored_value = 16'h0000;
        end
      end
      gvs_pkg::ST_SCAN: begin
        ram_re = !match && (rd_idx < fill);
        if (match) begin
          ram_we                = 1'b1;
          ram_waddr             = chk_idx;
          res_load              = 1'b1;
          res_next.outcome      = gvs_pkg::OUT_UPDATED;
          res_next.slot_index   = slot_wide_chk[7:0];
          res_next.stored_value = work.value;
        end else if (scan_done) begin
          res_load              = 1'b1;
          res_next.stored_value = work.value;
          if (has_room) begin
            ram_we              = 1'b1;
            fill_inc            = (work.group_address != gvs_pkg::FREE_MARK);
            res_next.outcome    = gvs_pkg::OUT_INSERTED;
            res_next.slot_index = slot_wide_ins[7:0];
          end else begin
            res_next.outcome    = gvs_pkg::OUT_FULL;
            res_next.slot_index = 8'h00;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gvs_pkg::ST_IDLE;
      fill         <= '0;
      rd_idx       <= '0;
      chk_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fill_inc) begin
        fill <= fill + CNTW'(1);
      end
      if (state == gvs_pkg::ST_IDLE) begin
        rd_idx    <= '0;
        chk_valid <= 1'b0;
      end else if (ram_re) begin
        rd_idx    <= rd_idx + CNTW'(1);
        chk_valid <= 1'b1;
      end else begin
        chk_valid <= 1'b0;
      end
      if (state == gvs_pkg::ST_EMIT && emit_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gvs_pkg::ST_IDLE && pop_valid) begin
      work <= pop_data;
    end
    if (ram_re) begin
      chk_idx <= rd_idx[IDXW-1:0];
    end
    if (res_load) begin
      res <= res_next;
    end
    if (state == gvs_pkg::ST_EMIT && emit_free) begin
      result <= res;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNTW'(SLOT_COUNT))
    else $error("fill count beyond slot count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |->
      (fill == $past(fill) + CNTW'(1)) && ($past(state) == gvs_pkg::ST_SCAN))
    else $error("fill count moved outside an insert");

  a_write_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> state == gvs_pkg::ST_EMIT)
    else $error("slot write did not end the scan");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> state == gvs_pkg::ST_SCAN)
    else $error("pending compare outside scan");

endmodule

/* verif/gvs_store_checker.sv */
`timescale 1ns / 1ps
module gvs_store_checker
  import gvs_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_ready,
  input  req_item_t    req,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result,
  output int           fail_count,
  output int           pending_results
);

  logic [15:0]  slot_address [SLOT_COUNT];
  logic [15:0]  slot_value [SLOT_COUNT];
  logic [8:0]   used_slots;
  result_item_t awaited_results [$];

  function automatic logic [15:0] telegram_value(input req_item_t t);
    case (t.length_field)
      LEN_SHORT: return {8'h00, t.short_payload & SHORT_MASK};
      LEN_BYTE:  return {8'h00, t.payload_high};
      LEN_WORD:  return {t.payload_high, t.payload_low};
      default:   return 16'h0000;
    endcase
  endfunction

  // first slot holding the address or free takes it; 0xFFFF leaves the slot free
  task automatic store_telegram(input req_item_t t, output result_item_t r);
    logic [15:0] v;
    bit          placed;
    r = '0;
    if (t.length_field > LEN_WORD) begin
      r.outcome = OUT_IGNORED;
      return;
    end
    v = telegram_value(t);
    r.outcome = OUT_FULL;
    r.stored_value = v;
    placed = 1'b0;
    for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
      if (slot_address[i] == t.group_address || slot_address[i] == FREE_MARK) begin
        if (slot_address[i] == FREE_MARK) begin
          r.outcome = OUT_INSERTED;
          if (t.group_address != FREE_MARK && used_slots != 9'h1FF) used_slots++;
        end else begin
          r.outcome = OUT_UPDATED;
        end
        slot_address[i] = t.group_address;
        slot_value[i] = v;
        r.slot_index = 8'(i);
        placed = 1'b1;
      end
    end
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_item_t want;
    result_item_t predicted;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_address[i] = FREE_MARK;
        slot_value[i] = 16'h0000;
      end
      used_slots = '0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          log_failure($sformatf("unexpected result: outcome %0d slot %0d value %04h",
                                result.outcome, result.slot_index, result.stored_value));
        end else begin
          want = awaited_results.pop_front();
          if (result.outcome !== want.outcome || result.slot_index !== want.slot_index ||
              result.stored_value !== want.stored_value) begin
            log_failure($sformatf(
              "result mismatch: exp outcome %0d slot %0d value %04h, got %0d %0d %04h",
              want.outcome, want.slot_index, want.stored_value,
              result.outcome, result.slot_index, result.stored_value));
          end
        end
      end
      if (req_valid && req_ready) begin
        store_telegram(req, predicted);
        awaited_results.push_back(predicted);
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import gvs_pkg::*;

  logic         clk;
  logic         rst;
  logic         req_valid;
  logic         req_ready;
  req_item_t    req;
  logic         result_valid;
  logic         result_ready;
  result_item_t result;
  int           fail_count;
  int           pending_results;
  logic [15:0]  known_addresses [$];
  int           burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  group_value_store_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  gvs_store_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk) req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_telegram(input logic [15:0] addr, input logic [3:0] len,
                               input logic [7:0] b7, input logic [7:0] b8,
                               input logic [7:0] b9);
    @(negedge clk);
    req <= '{group_address: addr, length_field: len, short_payload: b7,
             payload_high: b8, payload_low: b9};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pace_sender();
  endtask

  task automatic drain_results();
    @(negedge clk) req_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // receiver: runs of steady ready, hard stalls and random toggling
  initial begin
    int mode;
    int run;
    result_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      run = $urandom_range(1, (mode == 0) ? 60 : 12);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'b0;
          default: result_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    int          counted;
    int          pick;
    logic [15:0] addr;
    logic [3:0]  len;
    req_valid = 1'b0;
    req = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_telegram(16'h0000, LEN_NONE, 8'hFF, 8'hFF, 8'hFF);
    send_telegram(16'h0000, LEN_SHORT, 8'hFF, 8'h00, 8'h00);
    send_telegram(16'h0000, LEN_SHORT, 8'hC0, 8'hFF, 8'hFF);
    send_telegram(16'h1234, LEN_BYTE, 8'h00, 8'hFF, 8'h00);
    send_telegram(16'h1234, LEN_WORD, 8'h00, 8'hFF, 8'hFF);
    send_telegram(16'hFFFE, LEN_WORD, 8'hFF, 8'h00, 8'h00);
    send_telegram(FREE_MARK, LEN_WORD, 8'h00, 8'hAB, 8'hCD);
    send_telegram(FREE_MARK, LEN_SHORT, 8'h2A, 8'h00, 8'h00);
    send_telegram(16'h8001, LEN_BYTE, 8'h00, 8'h80, 8'h00);
    send_telegram(FREE_MARK, LEN_NONE, 8'h00, 8'h00, 8'h00);
    send_telegram(16'hFFFF, 4'd4, 8'h11, 8'h22, 8'h33);
    send_telegram(16'h0000, 4'd15, 8'hFF, 8'hFF, 8'hFF);
    send_telegram(16'h5555, 4'd8, 8'h00, 8'h00, 8'h00);
    send_telegram(16'hAAAA, 4'd7, 8'h5A, 8'hA5, 8'h3C);
    send_telegram(16'h8001, LEN_NONE, 8'hFF, 8'hFF, 8'hFF);
    send_telegram(16'h7FFF, LEN_WORD, 8'h80, 8'h80, 8'h01);
    known_addresses = '{16'h0000, 16'h1234, 16'hFFFE, 16'h8001, 16'h7FFF};
    drain_results();

    // new addresses fill the table partway through; later inserts hit the full case
    counted = 0;
    while (counted < 1750) begin
      pick = $urandom_range(0, 99);
      len = 4'($urandom_range(0, 3));
      counted++;
      if (pick < 8) begin
        len = 4'($urandom_range(4, 15));
        addr = 16'($urandom);
      end else begin
        if (pick < 12) begin
          addr = FREE_MARK;
        end else if (pick < 45 || known_addresses.size() == 0) begin
          addr = 16'($urandom_range(0, 16'hFFFE));
          known_addresses.push_back(addr);
        end else begin
          addr = known_addresses[$urandom_range(0, known_addresses.size() - 1)];
        end
      end
      send_telegram(addr, len, 8'($urandom), 8'($urandom), 8'($urandom));
      if (counted == 875) drain_results();
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/gvs_pkg.sv
hw/rtl/gvs_ram.sv
hw/rtl/gvs_fifo.sv
hw/rtl/gvs_front.sv
hw/rtl/gvs_back.sv
hw/rtl/group_value_store_core.sv
verif/gvs_store_checker.sv
verif/tb_top.sv
